// ----- design/m3i_pkg.sv -----
// shared constants and types for the 3x3 matrix inverse block
package m3i_pkg;

    // default element format: signed Q16.16
    localparam int M3I_DATA_WIDTH  = 32;
    localparam int M3I_FRAC_BITS   = 16;

    // entries in the queue between the cofactor front and the divider back
    localparam int M3I_QUEUE_DEPTH = 4;

    // bit positions in the status field
    localparam int M3I_ST_SINGULAR  = 0;
    localparam int M3I_ST_SATURATED = 1;

    // queue fill status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } m3i_fifo_stat_t;

endpackage

// ----- design/m3i_front.sv -----
// front pipeline: cofactors, determinant, singular check and divisor setup
module m3i_front import m3i_pkg::*; #(
    parameter int DATA_WIDTH = M3I_DATA_WIDTH,
    parameter int FRAC_BITS  = M3I_FRAC_BITS,
    parameter int DM_W       = 3 * M3I_DATA_WIDTH + 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [8:0][DATA_WIDTH-1:0]         in_elem,
    input  m3i_fifo_stat_t                     fifo_stat,
    output logic                               out_push,
    output logic [8:0][2*DATA_WIDTH-1:0]       out_cmag,
    output logic [8:0]                         out_qneg,
    output logic [DM_W-1:0]                    out_dmag,
    output logic [DATA_WIDTH-1:0]              out_det_val,
    output logic                               out_det_sat,
    output logic                               out_sing
);
    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int CW   = 2 * W + 1;
    localparam int MW   = 2 * W;
    localparam int NST  = 7;

    localparam logic signed [DM_W-1:0] BIAS = {{(DM_W-2*F){1'b0}}, {(2*F){1'b1}}};
    localparam logic [DM_W-1:0]        ONE3 = {{(DM_W-3*F-1){1'b0}}, 1'b1, {(3*F){1'b0}}};

    logic [NST-1:0] v_reg;
    logic           en;

    logic signed [W-1:0]    a0_reg [3][3];
    logic signed [PW-1:0]   p0_reg [3][3];
    logic signed [PW-1:0]   p1_reg [3][3];
    logic signed [W-1:0]    a1_reg [3];
    logic signed [W-1:0]    a2_reg [3];
    logic signed [CW-1:0]   cof2_reg [3][3];
    logic signed [2*W:0]    lo_reg [3];
    logic signed [2*W:0]    hi_reg [3];
    logic signed [CW-1:0]   cof3_reg [3][3];
    logic signed [DM_W-1:0] term_reg [3];
    logic signed [CW-1:0]   cof4_reg [3][3];
    logic signed [DM_W-1:0] det_reg;
    logic [MW-1:0]          cmag5_reg [9];
    logic [8:0]             cneg5_reg;

    logic [8:0][MW-1:0]     cmag6_reg;
    logic [8:0]             qneg6_reg;
    logic [DM_W-1:0]        dmag6_reg;
    logic [W-1:0]           dval6_reg;
    logic                   dsat6_reg;
    logic                   sing6_reg;

    // whole pipe moves unless the last stage holds a beat the queue cannot take
    assign en       = !v_reg[NST-1] || !fifo_stat.full;
    assign in_ready = en;
    assign out_push = v_reg[NST-1] && !fifo_stat.full;

    // stage valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    // capture, two-by-two products, cofactor differences
    for (genvar gr = 0; gr < 3; gr++) begin : g_row
        for (genvar gc = 0; gc < 3; gc++) begin : g_col
            localparam int R1 = (gr + 1) % 3;
            localparam int R2 = (gr + 2) % 3;
            localparam int C1 = (gc + 1) % 3;
            localparam int C2 = (gc + 2) % 3;
            always_ff @(posedge aclk) begin
                if (en) begin
                    a0_reg[gr][gc]   <= in_elem[gr*3+gc];
                    p0_reg[gr][gc]   <= a0_reg[R1][C1] * a0_reg[R2][C2];
                    p1_reg[gr][gc]   <= a0_reg[R1][C2] * a0_reg[R2][C1];
                    cof2_reg[gr][gc] <= {p0_reg[gr][gc][PW-1], p0_reg[gr][gc]}
                                      - {p1_reg[gr][gc][PW-1], p1_reg[gr][gc]};
                    cof3_reg[gr][gc] <= cof2_reg[gr][gc];
                    cof4_reg[gr][gc] <= cof3_reg[gr][gc];
                end
            end
        end
    end

    // determinant along row 0: split the wide cofactor into two partial products
    for (genvar gc = 0; gc < 3; gc++) begin : g_det
        always_ff @(posedge aclk) begin
            if (en) begin
                a1_reg[gc]   <= a0_reg[0][gc];
                a2_reg[gc]   <= a1_reg[gc];
                lo_reg[gc]   <= a2_reg[gc] * $signed({1'b0, cof2_reg[0][gc][W-1:0]});
                hi_reg[gc]   <= a2_reg[gc] * $signed(cof2_reg[0][gc][CW-1:W]);
                term_reg[gc] <= (DM_W'(hi_reg[gc]) <<< W) + DM_W'(lo_reg[gc]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
        end
    end

    // cofactor magnitudes, transposed into adjugate order
    for (genvar gi = 0; gi < 3; gi++) begin : g_adj_i
        for (genvar gj = 0; gj < 3; gj++) begin : g_adj_j
            logic [CW-1:0] c_abs;
            assign c_abs = cof4_reg[gj][gi][CW-1] ? (~cof4_reg[gj][gi] + CW'(1))
                                                  : cof4_reg[gj][gi];
            always_ff @(posedge aclk) begin
                if (en) begin
                    cmag5_reg[gi*3+gj] <= c_abs[MW-1:0];
                    cneg5_reg[gi*3+gj] <= cof4_reg[gj][gi][CW-1];
                end
            end
        end
    end

    // classify: singular divisor, determinant output with truncation and saturation
    logic                   sing;
    logic                   dneg;
    logic [DM_W-1:0]        dabs;
    logic signed [DM_W-1:0] bias_sel;
    logic signed [DM_W-1:0] dsum;
    logic signed [DM_W-1:0] dt;
    logic                   dfits;

    always_comb begin
        sing     = (det_reg == '0);
        dneg     = det_reg[DM_W-1];
        dabs     = dneg ? (~det_reg + DM_W'(1)) : det_reg;
        bias_sel = dneg ? BIAS : '0;
        dsum     = det_reg + bias_sel;
        dt       = dsum >>> (2 * F);
        dfits    = (&dt[DM_W-1:W-1]) || !(|dt[DM_W-1:W-1]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                cmag6_reg[k] <= cmag5_reg[k];
            end
            qneg6_reg <= cneg5_reg ^ {9{dneg}};
            dmag6_reg <= sing ? ONE3 : dabs;
            dval6_reg <= dfits ? dt[W-1:0]
                               : (dt[DM_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
            dsat6_reg <= !dfits;
            sing6_reg <= sing;
        end
    end

    assign out_cmag    = cmag6_reg;
    assign out_qneg    = qneg6_reg;
    assign out_dmag    = dmag6_reg;
    assign out_det_val = dval6_reg;
    assign out_det_sat = dsat6_reg;
    assign out_sing    = sing6_reg;

endmodule

// ----- design/m3i_fifo.sv -----
// short first-word-fall-through queue between front and back
module m3i_fifo import m3i_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = M3I_QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output m3i_fifo_stat_t   stat
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;

    assign stat.full  = (count_reg == NW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + NW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> !stat.empty)
        else $error("queue empty right after a push");

endmodule

// ----- design/m3i_div.sv -----
// one restoring divider lane: one quotient bit per stage, magnitudes only
module m3i_div import m3i_pkg::*; #(
    parameter int DATA_WIDTH = M3I_DATA_WIDTH,
    parameter int FRAC_BITS  = M3I_FRAC_BITS,
    parameter int DM_W       = 3 * M3I_DATA_WIDTH + 2
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [2*DATA_WIDTH-1:0] num_mag,
    input  logic                    num_neg,
    input  logic [DM_W-1:0]         div_mag,
    output logic [DATA_WIDTH:0]     quo_mag,
    output logic                    quo_neg
);
    localparam int W     = DATA_WIDTH;
    localparam int MW    = 2 * W;
    localparam int NW    = MW + 2 * FRAC_BITS;
    localparam int CMPW  = ((NW > DM_W + W) ? NW : DM_W + W) + 1;
    localparam int STEPS = W + 1;

    logic [CMPW-1:0] r_reg [STEPS];
    logic [DM_W-1:0] d_reg [STEPS];
    logic [W:0]      q_reg [STEPS];
    logic            n_reg [STEPS];

    // stage s settles quotient bit W-s; bit W set means the quotient overflows
    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam int J = W - s;
        logic [CMPW-1:0] r_in;
        logic [DM_W-1:0] d_in;
        logic [W:0]      q_in;
        logic            n_in;
        logic [CMPW-1:0] shifted;
        logic [CMPW:0]   diff;
        logic            ge;

        if (s == 0) begin : g_first
            assign r_in = CMPW'(num_mag) << (2 * FRAC_BITS);
            assign d_in = div_mag;
            assign q_in = '0;
            assign n_in = num_neg;
        end else begin : g_next
            assign r_in = r_reg[s-1];
            assign d_in = d_reg[s-1];
            assign q_in = q_reg[s-1];
            assign n_in = n_reg[s-1];
        end

        always_comb begin
            shifted = CMPW'(d_in) << J;
            diff    = {1'b0, r_in} - {1'b0, shifted};
            ge      = !diff[CMPW];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[s] <= ge ? diff[CMPW-1:0] : r_in;
                d_reg[s] <= d_in;
                q_reg[s] <= q_in | ((W + 1)'(ge) << J);
                n_reg[s] <= n_in;
            end
        end
    end

    assign quo_mag = q_reg[STEPS-1];
    assign quo_neg = n_reg[STEPS-1];

endmodule

// ----- design/m3i_back.sv -----
// back end: nine divider lanes, result signs, saturation and output register
module m3i_back import m3i_pkg::*; #(
    parameter int DATA_WIDTH = M3I_DATA_WIDTH,
    parameter int FRAC_BITS  = M3I_FRAC_BITS,
    parameter int DM_W       = 3 * M3I_DATA_WIDTH + 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  m3i_fifo_stat_t               fifo_stat,
    output logic                         pop,
    input  logic [8:0][2*DATA_WIDTH-1:0] in_cmag,
    input  logic [8:0]                   in_qneg,
    input  logic [DM_W-1:0]              in_dmag,
    input  logic [DATA_WIDTH-1:0]        in_det_val,
    input  logic                         in_det_sat,
    input  logic                         in_sing,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [8:0][DATA_WIDTH-1:0]   out_inv,
    output logic [DATA_WIDTH-1:0]        out_det_val,
    output logic [1:0]                   out_status
);
    localparam int W     = DATA_WIDTH;
    localparam int STEPS = W + 1;

    localparam logic [W:0]   LIM_POS = {2'b00, {(W-1){1'b1}}};
    localparam logic [W:0]   LIM_NEG = {2'b01, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXV    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV    = {1'b1, {(W-1){1'b0}}};

    logic             en;
    logic [STEPS-1:0] vp_reg;
    logic [W-1:0]     dval_reg [STEPS];
    logic [STEPS-1:0] dsat_reg;
    logic [STEPS-1:0] sing_reg;
    logic             out_valid_reg;
    logic [8:0][W-1:0] inv_reg;
    logic [W-1:0]     odet_reg;
    logic [1:0]       ostat_reg;

    logic [W:0]       qm [9];
    logic [8:0]       qn;

    // the whole back pipe halts only while a result waits at the output
    assign en  = !out_valid_reg || out_ready;
    assign pop = !fifo_stat.empty && en;

    for (genvar k = 0; k < 9; k++) begin : g_lane
        m3i_div #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .DM_W       (DM_W)
        ) u_div (
            .aclk    (aclk),
            .en      (en),
            .num_mag (in_cmag[k]),
            .num_neg (in_qneg[k]),
            .div_mag (in_dmag),
            .quo_mag (qm[k]),
            .quo_neg (qn[k])
        );
    end

    // valid and side data travel alongside the lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vp_reg        <= {vp_reg[STEPS-2:0], pop};
            out_valid_reg <= vp_reg[STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dval_reg[0] <= in_det_val;
            for (int s = 1; s < STEPS; s++) begin
                dval_reg[s] <= dval_reg[s-1];
            end
            dsat_reg <= {dsat_reg[STEPS-2:0], in_det_sat};
            sing_reg <= {sing_reg[STEPS-2:0], in_sing};
        end
    end

    // apply sign and clamp each quotient to the signed range
    logic [8:0][W-1:0] inv_next;
    logic [8:0]        lane_sat;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            logic [W:0] negq;
            negq = ~qm[k] + (W + 1)'(1);
            if (qn[k]) begin
                lane_sat[k] = (qm[k] > LIM_NEG);
                inv_next[k] = lane_sat[k] ? MINV : negq[W-1:0];
            end else begin
                lane_sat[k] = (qm[k] > LIM_POS);
                inv_next[k] = lane_sat[k] ? MAXV : qm[k][W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en) begin
            inv_reg   <= inv_next;
            odet_reg  <= dval_reg[STEPS-1];
            ostat_reg[M3I_ST_SINGULAR]  <= sing_reg[STEPS-1];
            ostat_reg[M3I_ST_SATURATED] <= dsat_reg[STEPS-1] || (|lane_sat);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_inv     = inv_reg;
    assign out_det_val = odet_reg;
    assign out_status  = ostat_reg;

endmodule

// ----- design/matrix3x3_inverse.sv -----
// top level: streaming 3x3 matrix inverse by adjugate over determinant
// Takes one 3x3 matrix of signed fixed-point elements per beat and returns the
// inverse (adjugate divided by the determinant, truncated toward zero,
// saturated), the determinant itself and two status bits: singular (zero
// determinant, plain adjugate returned) and saturated (any value clamped).
// One matrix is accepted every cycle while the output is taken. A matrix
// passes 7 front stages for products, cofactors and determinant, is written
// into the queue, then passes DATA_WIDTH+1 divider stages, each settling one
// quotient bit in all nine lanes, and the output register. A stalled output
// fills the queue and then holds s_tready low.
module matrix3x3_inverse import m3i_pkg::*; #(
    parameter int DATA_WIDTH = M3I_DATA_WIDTH,
    parameter int FRAC_BITS  = M3I_FRAC_BITS
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2, a_r2c0, a_r2c1, a_r2c2
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]         s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // inv_r0c0 .. inv_r2c2 (row major), det_value
    output logic [((10*DATA_WIDTH+7)/8)*8-1:0]        m_tdata,
    // status_flags: bit0 singular, bit1 saturated
    output logic [1:0]                                m_tuser
);
    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int MW   = 2 * W;
    localparam int DM_W = (3 * W + 2 > 3 * F + 2) ? 3 * W + 2 : 3 * F + 2;
    localparam int MDW  = ((10 * W + 7) / 8) * 8;
    localparam int EW   = 9 * MW + 9 + DM_W + W + 2;

    localparam int O_QNEG = 9 * MW;
    localparam int O_DMAG = O_QNEG + 9;
    localparam int O_DVAL = O_DMAG + DM_W;
    localparam int O_DSAT = O_DVAL + W;
    localparam int O_SING = O_DSAT + 1;

    m3i_fifo_stat_t    fifo_stat;
    logic              push;
    logic              pop;
    logic [EW-1:0]     wr_data;
    logic [EW-1:0]     rd_data;

    logic [8:0][W-1:0] in_elem;
    logic [8:0][MW-1:0] f_cmag;
    logic [8:0]        f_qneg;
    logic [DM_W-1:0]   f_dmag;
    logic [W-1:0]      f_dval;
    logic              f_dsat;
    logic              f_sing;

    logic [8:0][W-1:0] b_inv;
    logic [W-1:0]      b_det;

    assign in_elem = s_tdata[9*W-1:0];

    m3i_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .DM_W       (DM_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_elem     (in_elem),
        .fifo_stat   (fifo_stat),
        .out_push    (push),
        .out_cmag    (f_cmag),
        .out_qneg    (f_qneg),
        .out_dmag    (f_dmag),
        .out_det_val (f_dval),
        .out_det_sat (f_dsat),
        .out_sing    (f_sing)
    );

    // queue entry, low to high: magnitudes, signs, divisor, det value, det sat, singular
    assign wr_data = {f_sing, f_dsat, f_dval, f_dmag, f_qneg, f_cmag};

    m3i_fifo #(
        .WIDTH (EW),
        .DEPTH (M3I_QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (wr_data),
        .pop     (pop),
        .rd_data (rd_data),
        .stat    (fifo_stat)
    );

    m3i_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .DM_W       (DM_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fifo_stat   (fifo_stat),
        .pop         (pop),
        .in_cmag     (rd_data[O_QNEG-1:0]),
        .in_qneg     (rd_data[O_QNEG +: 9]),
        .in_dmag     (rd_data[O_DMAG +: DM_W]),
        .in_det_val  (rd_data[O_DVAL +: W]),
        .in_det_sat  (rd_data[O_DSAT]),
        .in_sing     (rd_data[O_SING]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_inv     (b_inv),
        .out_det_val (b_det),
        .out_status  (m_tuser)
    );

    // result beat packing
    assign m_tdata[9*W-1:0]    = b_inv;
    assign m_tdata[9*W +: W]   = b_det;
    if (MDW > 10 * W) begin : g_pad
        assign m_tdata[MDW-1:10*W] = '0;
    end

    a_sing_det_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[M3I_ST_SINGULAR]) |-> (m_tdata[9*W +: W] == '0))
        else $error("singular result with nonzero determinant");

endmodule

// ----- test/matrix3x3_inverse_check.sv -----
// checker for the 3x3 matrix inverse: predicts each result beat and compares it
module matrix3x3_inverse_check import m3i_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [319:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           pending,
    output int           errors
);

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic [31:0] elem [10];
        logic [1:0]  flags;
    } inverse_t;

    inverse_t expected_inv [$];

    // clamp an exact value to the signed 32-bit range
    function automatic logic [31:0] clamp32(input wide_t v, inout bit sat);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< 31) - 1;
        lo = -(wide_t'(1) <<< 31);
        if (v > hi) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end else if (v < lo) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // exact adjugate over determinant, truncated toward zero
    function automatic inverse_t invert(input logic [287:0] d);
        wide_t    a [3][3];
        wide_t    cof [3][3];
        wide_t    det;
        wide_t    divisor;
        wide_t    num;
        bit       sat;
        bit       sing;
        inverse_t res;
        sat = 1'b0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                a[r][c] = $signed(d[32*(r*3+c) +: 32]);
        // signed cofactors by cyclic indexing
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                cof[r][c] = a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3]
                          - a[(r+1)%3][(c+2)%3] * a[(r+2)%3][(c+1)%3];
        det = 0;
        for (int c = 0; c < 3; c++)
            det = det + a[0][c] * cof[0][c];
        sing = (det == 0);
        res.elem[9] = clamp32(det / (wide_t'(1) <<< (2*M3I_FRAC_BITS)), sat);
        // a zero determinant divides by one instead
        divisor = sing ? (wide_t'(1) <<< (3*M3I_FRAC_BITS)) : det;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                num = cof[j][i] <<< (2*M3I_FRAC_BITS);
                res.elem[i*3+j] = clamp32(num / divisor, sat);
            end
        res.flags = 2'b00;
        res.flags[M3I_ST_SINGULAR]  = sing;
        res.flags[M3I_ST_SATURATED] = sat;
        return res;
    endfunction

    assign pending = expected_inv.size();

    initial errors = 0;

    // predict on input beats, compare on output beats
    always @(posedge aclk) begin
        inverse_t want;
        int       bad;
        bad = 0;
        if (aresetn && s_tvalid && s_tready)
            expected_inv.push_back(invert(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_inv.size() == 0) begin
                $error("result beat with no matrix pending");
                bad = bad + 1;
            end else begin
                want = expected_inv.pop_front();
                for (int k = 0; k < 10; k++)
                    if (m_tdata[32*k +: 32] !== want.elem[k]) begin
                        if (k == 9)
                            $error("det_value: expected %h, got %h", want.elem[k],
                                   m_tdata[32*k +: 32]);
                        else
                            $error("inv_r%0dc%0d: expected %h, got %h", k/3, k%3,
                                   want.elem[k], m_tdata[32*k +: 32]);
                        bad = bad + 1;
                    end
                if (m_tuser !== want.flags) begin
                    $error("status_flags: expected %b, got %b", want.flags, m_tuser);
                    bad = bad + 1;
                end
            end
        end
        if (bad != 0)
            errors <= errors + bad;
    end

endmodule

// ----- test/matrix3x3_inverse_test.sv -----
// testbench top for the 3x3 matrix inverse: stimulus, flow control and verdict
module matrix3x3_inverse_test;
    import m3i_pkg::*;

    localparam int RANDOM_MATRICES = 1250;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [319:0] m_tdata;
    logic [1:0]   m_tuser;
    int           pending;
    int           errors;
    int           sent = 0;
    bit           stall_req = 1'b0;
    int           stall_left = 0;

    always #4 aclk = ~aclk;

    matrix3x3_inverse u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    matrix3x3_inverse_check u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .pending(pending), .errors(errors)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // receiver: random ready, always ready while sent is between 300 and 500, plus one long hold-off on request
    always @(posedge aclk) begin
        if (stall_req && stall_left == 0) begin
            stall_req  <= 1'b0;
            stall_left <= 400;
            m_tready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (sent > 300 && sent < 500) begin
            m_tready   <= 1'b1;
        end else begin
            m_tready   <= ($urandom_range(99) < 70);
        end
    end

    // offer one matrix beat, wait for it to be taken, then idle for a random gap
    task automatic send_matrix(input logic [31:0] e [9]);
        int g;
        for (int k = 0; k < 9; k++)
            s_tdata[32*k +: 32] <= e[k];
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent = sent + 1;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic fill(output logic [31:0] e [9], input logic [31:0] v);
        for (int k = 0; k < 9; k++) e[k] = v;
    endtask

    // diagonal matrix with the given diagonal and zero elsewhere
    task automatic diag(output logic [31:0] e [9], input logic [31:0] v);
        fill(e, 32'h0);
        e[0] = v; e[4] = v; e[8] = v;
    endtask

    // random element: full range, small fixed-point, or tiny raw
    function automatic logic [31:0] rand_elem(input int kind);
        case (kind)
            0: return $urandom;
            1: return $unsigned($signed($urandom_range(524288)) - 262144);
            default: return $unsigned($signed($urandom_range(64)) - 32);
        endcase
    endfunction

    initial begin
        logic [31:0] m [9];
        int kind;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero, identity, extremes, singular, tiny determinant
        fill(m, 32'h0);            send_matrix(m);
        diag(m, 32'h0001_0000);    send_matrix(m);
        diag(m, 32'hffff_0000);    send_matrix(m);
        diag(m, 32'h0000_0001);    send_matrix(m);
        diag(m, 32'h0000_0100);    send_matrix(m);
        diag(m, 32'h7fff_ffff);    send_matrix(m);
        diag(m, 32'h8000_0000);    send_matrix(m);
        diag(m, 32'h0200_0000);    send_matrix(m);
        fill(m, 32'h7fff_ffff);    send_matrix(m);
        fill(m, 32'h8000_0000);    send_matrix(m);
        fill(m, 32'hffff_ffff);    send_matrix(m);
        fill(m, 32'h0001_0000);    send_matrix(m);
        fill(m, 32'h8000_0000);
        m[1] = 32'h7fff_ffff; m[5] = 32'h7fff_ffff; m[6] = 32'h7fff_ffff;
        send_matrix(m);
        // singular with nonzero adjugate
        fill(m, 32'h0);
        m[0] = 32'h0001_0000; m[1] = 32'h0002_0000; m[4] = 32'h0001_0000;
        send_matrix(m);
        // rotation-like well-conditioned matrix
        fill(m, 32'h0);
        m[0] = 32'h0000_b505; m[1] = 32'hffff_4afb; m[3] = 32'h0000_b505;
        m[4] = 32'h0000_b505; m[8] = 32'h0001_0000;
        send_matrix(m);
        // scaled permutation with negative entry
        fill(m, 32'h0);
        m[1] = 32'h0001_0000; m[5] = 32'hffff_0000; m[6] = 32'h0003_0000;
        send_matrix(m);

        // random: mostly invertible near-diagonal, some rank-deficient, the rest raw noise
        for (int n = 0; n < RANDOM_MATRICES; n++) begin
            if (n == 600) stall_req = 1'b1;
            kind = $urandom_range(99);
            if (kind < 60) begin
                for (int k = 0; k < 9; k++) m[k] = rand_elem(1);
                for (int k = 0; k < 9; k += 4)
                    m[k] = $unsigned($signed(m[k]) + 32'sh0008_0000);
            end else if (kind < 75) begin
                for (int k = 0; k < 9; k++) m[k] = rand_elem(0);
            end else if (kind < 85) begin
                for (int k = 0; k < 9; k++) m[k] = rand_elem(2);
            end else if (kind < 93) begin
                // rank-deficient: third row copies the first
                for (int k = 0; k < 6; k++) m[k] = rand_elem(1);
                for (int k = 6; k < 9; k++) m[k] = m[k-6];
            end else begin
                for (int k = 0; k < 9; k++) m[k] = rand_elem($urandom_range(2));
            end
            send_matrix(m);
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial begin
        #(8 * 400000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
